// ----- sv/tmcw_pkg.sv -----
// tmcw_pkg: shared constants, types and codes for the text-mode console writer
`default_nettype none
package tmcw_pkg;

    // screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);

    // character codes
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [CHAR_W-1:0] TEXT_COLOUR_RESET = 8'd7;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_WRITE,
        S_RD,
        S_DONE
    } t_state;

    // controls from the sequencer to the row map
    typedef struct packed {
        logic             scroll;
        logic             mark_valid;
        logic [ROW_W-1:0] mark_row;
    } t_map_ctrl;

endpackage
`default_nettype wire

// ----- sv/tmcw_screen_ram.sv -----
// tmcw_screen_ram: single-port synchronous RAM with registered read data
`default_nettype none
module tmcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- sv/tmcw_row_map.sv -----
// tmcw_row_map: ring offset of screen rows and per-row written flags
`default_nettype none
module tmcw_row_map (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tmcw_pkg::t_map_ctrl     i_ctrl,
    input  logic [tmcw_pkg::ROW_W-1:0] i_lrow,
    output logic [tmcw_pkg::ROW_W-1:0] o_prow,
    output logic                    o_prow_valid
);
    import tmcw_pkg::*;

    logic [ROW_W-1:0]       r_top;
    logic [SCREEN_ROWS-1:0] r_row_valid;
    logic [ROW_W:0]         sum;

    // logical row to physical row, modulo the row count
    always_comb begin
        sum = {1'b0, i_lrow} + {1'b0, r_top};
        if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
            sum = sum - (ROW_W+1)'(SCREEN_ROWS);
        end
        o_prow       = sum[ROW_W-1:0];
        o_prow_valid = r_row_valid[o_prow];
    end

    // scroll moves the top row and drops the old top, which becomes the new bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_row_valid <= '0;
        end else begin
            if (i_ctrl.scroll) begin
                r_row_valid[r_top] <= 1'b0;
                r_top <= (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
            end
            if (i_ctrl.mark_valid) begin
                r_row_valid[i_ctrl.mark_row] <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/text_mode_console_writer.sv -----
// text_mode_console_writer: top level, transaction sequencer and cursor logic
//
// Text console of 25 rows by 80 cells of 16 bits (character low byte, colour
// high byte) held in one single-port screen RAM, plus a cursor. Puts handle
// newline, backspace, line wrap and scroll; reads return one cell. A read or a
// put goes through S_RD or S_WRITE and then S_DONE, which loads the output
// register; a newline goes straight from S_IDLE to S_DONE. S_DONE waits while
// the output is stalled, and the input is taken again back in S_IDLE.
// The first put into a row that has not been written since reset or since it
// scrolled in at the bottom adds a pass in S_CLEAR that zeroes that row through
// the RAM write port. Scrolling itself is a row offset that moves no RAM data, and
// there is no clearing pass after reset: unwritten rows read as zero. One
// transaction is worked on at a time; the input is taken again while a finished
// result still waits in the output register.
`default_nettype none
module text_mode_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_text_colour_we,
    input  logic [tmcw_pkg::CHAR_W-1:0]   i_text_colour,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [tmcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tmcw_pkg::ROW_W-1:0]    i_read_row,
    input  logic [tmcw_pkg::COL_W-1:0]    i_read_column,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tmcw_pkg::CELL_W-1:0]   o_cell_entry,
    output logic [tmcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]    o_cursor_column
);
    import tmcw_pkg::*;

    t_state              r_state, n_state;
    logic [CHAR_W-1:0]   r_colour;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_phys_row, n_phys_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [CELL_W-1:0]   r_wdata, n_wdata;
    logic                r_row_ok, n_row_ok;
    logic                r_is_read, n_is_read;
    logic [COL_W-1:0]    r_sweep_col, n_sweep_col;
    logic                r_out_valid, n_out_valid;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [ROW_W-1:0]    r_orow, n_orow;
    logic [COL_W-1:0]    r_ocol, n_ocol;

    logic                in_acc;
    logic                is_read_in;
    logic                in_range;
    logic                put_store;
    logic [COL_W-1:0]    put_col;
    logic [CELL_W-1:0]   put_data;
    logic [COL_W-1:0]    put_ncol;
    logic                put_rowinc;

    t_map_ctrl           map_ctrl;
    logic [ROW_W-1:0]    map_lrow;
    logic [ROW_W-1:0]    map_prow;
    logic                map_valid;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_rdata;
    logic [COL_W-1:0]    sel_col;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_read_in  = (t_op'(i_operation) == OP_READ);
    assign in_range    = (i_read_row <= LAST_ROW) && (i_read_column <= LAST_COL);
    assign map_lrow    = is_read_in ? i_read_row : r_cur_row;

    // put decode: where to store, and how the cursor moves
    always_comb begin
        put_store  = 1'b1;
        put_col    = r_cur_col;
        put_data   = {r_colour, i_char_code};
        put_ncol   = r_cur_col + 1'b1;
        put_rowinc = 1'b0;
        unique case (i_char_code)
            CODE_NEWLINE: begin
                put_store  = 1'b0;
                put_ncol   = '0;
                put_rowinc = 1'b1;
            end
            CODE_BACKSPACE: begin
                put_col  = (r_cur_col == '0) ? '0 : r_cur_col - 1'b1;
                put_data = {r_colour, CODE_SPACE};
                put_ncol = put_col;
            end
            default: begin
                if (r_cur_col == LAST_COL) begin
                    put_ncol   = '0;
                    put_rowinc = 1'b1;
                end
            end
        endcase
    end

    // sequencer: next state, RAM strobes and output register
    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_phys_row  = r_phys_row;
        n_col       = r_col;
        n_wdata     = r_wdata;
        n_row_ok    = r_row_ok;
        n_is_read   = r_is_read;
        n_sweep_col = r_sweep_col;
        n_out_valid = r_out_valid;
        n_cell      = r_cell;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        map_ctrl    = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = r_wdata;
        sel_col     = r_col;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_phys_row  = map_prow;
                    n_is_read   = is_read_in;
                    n_sweep_col = '0;
                    if (is_read_in) begin
                        n_col    = i_read_column;
                        n_row_ok = in_range && map_valid;
                        n_state  = S_RD;
                    end else begin
                        n_col     = put_col;
                        n_wdata   = put_data;
                        n_row_ok  = map_valid;
                        n_cur_col = put_ncol;
                        if (put_rowinc) begin
                            if (r_cur_row == LAST_ROW) begin
                                map_ctrl.scroll = 1'b1;
                            end else begin
                                n_cur_row = r_cur_row + 1'b1;
                            end
                        end
                        if (!put_store) begin
                            n_state = S_DONE;
                        end else if (map_valid) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_wdata   = '0;
                sel_col     = r_sweep_col;
                n_sweep_col = r_sweep_col + 1'b1;
                if (r_sweep_col == LAST_COL) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we              = 1'b1;
                map_ctrl.mark_valid = 1'b1;
                map_ctrl.mark_row   = r_phys_row;
                n_state             = S_DONE;
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_cell      = (r_is_read && r_row_ok) ? ram_rdata : '0;
                    n_orow      = r_cur_row;
                    n_ocol      = r_cur_col;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell address: physical row times row length plus column
    assign ram_addr = ADDR_W'(r_phys_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(sel_col);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour    <= TEXT_COLOUR_RESET;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_text_colour_we) begin
                r_colour <= i_text_colour;
            end
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
        end
    end

    // transaction and result payload
    always_ff @(posedge i_clk) begin
        r_phys_row  <= n_phys_row;
        r_col       <= n_col;
        r_wdata     <= n_wdata;
        r_row_ok    <= n_row_ok;
        r_is_read   <= n_is_read;
        r_sweep_col <= n_sweep_col;
        r_cell      <= n_cell;
        r_orow      <= n_orow;
        r_ocol      <= n_ocol;
    end

    tmcw_row_map u_row_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (map_ctrl),
        .i_lrow       (map_lrow),
        .o_prow       (map_prow),
        .o_prow_valid (map_valid)
    );

    tmcw_screen_ram #(
        .DEPTH (CELL_COUNT),
        .WIDTH (CELL_W)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_cell_entry    = r_cell;
    assign o_cursor_row    = r_orow;
    assign o_cursor_column = r_ocol;

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row <= LAST_ROW) && (r_cur_col <= LAST_COL))
        else $error("cursor outside the screen");

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

    // a cell write is always followed by result delivery
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_DONE))
        else $error("write not followed by result");

    // a row clear only runs on a put into a row not yet written
    a_clear_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_is_read && !r_row_ok))
        else $error("row clear on a written row or a read");

endmodule
`default_nettype wire
